### design/tws_pkg.sv
// tws_pkg: shared types, constants and helpers of the time-window event scheduler
// no dependencies; every other design file refers to it by scoped names
package tws_pkg;

  // time constants
  localparam int unsigned MinsPerHour  = 60;
  localparam int unsigned HoursPerDay  = 24;
  localparam int unsigned MinsPerDay   = MinsPerHour * HoursPerDay;

  // table size default and per-tick result cap
  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned ResultLimit   = 16;

  // input mode codes
  localparam logic ModeTick = 1'b0;
  localparam logic ModeAdd  = 1'b1;

  // result kind codes
  localparam logic [1:0] KindEvent = 2'd0;
  localparam logic [1:0] KindAdded = 2'd1;
  localparam logic [1:0] KindFull  = 2'd2;

  // one input item
  typedef struct packed {
    logic        mode;
    logic        time_valid;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [2:0]  weekday;
    logic [6:0]  new_day_mask;
    logic [3:0]  new_start_code;
    logic [4:0]  new_start_hour;
    logic [5:0]  new_start_minute;
    logic [10:0] new_duration;
    logic [3:0]  new_end_code;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [1:0] out_kind;
    logic [3:0] entry_index;
    logic [3:0] event_code;
    logic       last;
  } out_item_t;

  // one table entry, 41 bits
  typedef struct packed {
    logic [6:0]  day_mask;
    logic [10:0] start_min;
    logic [10:0] end_min;
    logic [3:0]  start_code;
    logic [3:0]  end_code;
    logic [3:0]  last_sent;
  } entry_t;

  // outcome of one entry on one tick
  typedef struct packed {
    logic       fire;
    logic [3:0] code;
    logic [3:0] last_sent;
  } eval_t;

  // fold a value below two days back into one day
  function automatic logic [10:0] wrap_day(input logic [11:0] v);
    logic [11:0] r;
    r = (v >= 12'(MinsPerDay)) ? (v - 12'(MinsPerDay)) : v;
    return r[10:0];
  endfunction

endpackage

### design/tws_in_if.sv
// tws_in_if: valid/ready channel that carries input items
// depends on tws_pkg for the payload type
interface tws_in_if;
  logic               valid;
  logic               ready;
  tws_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/tws_out_if.sv
// tws_out_if: valid/ready channel that carries result items
// depends on tws_pkg for the payload type
interface tws_out_if;
  logic                valid;
  logic                ready;
  tws_pkg::out_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/tws_entry_ram.sv
// tws_entry_ram: entry table, one write port and one registered read port
// depends on tws_pkg for the entry type
module tws_entry_ram #(
  parameter int unsigned Depth = tws_pkg::MaxEntriesDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  tws_pkg::entry_t     wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output tws_pkg::entry_t     rdata_o
);

  tws_pkg::entry_t mem [Depth];
  tws_pkg::entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data in the cycle after the request and held otherwise
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tws_window_eval.sv
// tws_window_eval: decides what one entry does on one valid tick
// depends on tws_pkg for the entry and outcome types
module tws_window_eval (
  input  tws_pkg::entry_t entry_i,
  input  logic [10:0]     now_i,
  input  logic [2:0]      wday_i,
  output tws_pkg::eval_t  result_o
);

  logic day_ok;
  logic open;
  logic armed;
  logic handled;

  always_comb begin
    // weekday seven selects no day bit
    day_ok  = (wday_i != 3'd7) && entry_i.day_mask[wday_i];
    armed   = (entry_i.last_sent == 4'd0);

    // window test, wrapping when it crosses midnight
    if (entry_i.start_min <= entry_i.end_min) begin
      open = (now_i >= entry_i.start_min) && (now_i <= entry_i.end_min);
    end else begin
      open = (now_i >= entry_i.start_min) || (now_i <= entry_i.end_min);
    end

    result_o.code      = 4'd0;
    result_o.last_sent = entry_i.last_sent;
    handled            = 1'b0;

    if (day_ok || !armed) begin
      if (open && armed) begin
        result_o.last_sent = entry_i.start_code;
        result_o.code      = entry_i.start_code;
        handled            = 1'b1;
      end else if (open && (entry_i.last_sent == entry_i.start_code) &&
                   (now_i == entry_i.end_min)) begin
        result_o.last_sent = entry_i.end_code;
        result_o.code      = entry_i.end_code;
        handled            = 1'b1;
      end
      // re-arm once the end code has been sent
      if (!handled && (entry_i.last_sent == entry_i.end_code)) begin
        result_o.last_sent = 4'd0;
      end
    end

    result_o.fire = (result_o.code != 4'd0);
  end

endmodule

### design/time_window_event_scheduler.sv
// time_window_event_scheduler: table of daily time windows, walked on each valid tick
// an add item gives its single result in the cycle after it is accepted
// a valid tick runs a read-modify-write walk through the entry memory, one entry per cycle
// unless the output stalls it; each result is held until the next one or the walk's end
// reset: rst_ni (async, active low) empties the table count and idles the walker;
// entry contents stay undefined until written and are never read before that
module time_window_event_scheduler #(
  parameter int unsigned MaxEntries = tws_pkg::MaxEntriesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tws_in_if.sink     in_i,
  tws_out_if.source  out_o
);

  localparam int unsigned IdxW   = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW   = $clog2(MaxEntries + 1);
  localparam int unsigned ResCntW = $clog2(tws_pkg::ResultLimit + 1);

  typedef enum logic [1:0] {StIdle, StWalk, StFlush} state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]     ev_idx_q, ev_idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic [10:0]         now_q, now_d;
  logic [2:0]          wday_q, wday_d;
  logic                pend_v_q, pend_v_d;
  logic [IdxW-1:0]     pend_idx_q, pend_idx_d;
  logic [3:0]          pend_code_q, pend_code_d;
  logic [ResCntW-1:0]  n_q, n_d;
  logic                out_v_q, out_v_d;
  tws_pkg::out_item_t  out_q, out_d;

  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  tws_pkg::entry_t     mem_wdata;
  logic                mem_re;
  logic [IdxW-1:0]     mem_raddr;
  tws_pkg::entry_t     mem_rdata;
  tws_pkg::eval_t      ev;

  logic                in_acc;
  logic                out_free;
  logic                tick_ok;
  logic                new_res;
  logic                stall;
  logic [10:0]         add_start;
  logic [10:0]         add_dur;
  tws_pkg::entry_t     add_entry;

  tws_entry_ram #(
    .Depth (MaxEntries),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tws_window_eval u_eval (
    .entry_i  (mem_rdata),
    .now_i    (now_q),
    .wday_i   (wday_q),
    .result_o (ev)
  );

  // handshakes
  assign in_i.ready    = (state_q == StIdle) && !out_v_q;
  assign in_acc        = in_i.valid && in_i.ready;
  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;
  assign out_free      = !out_v_q || out_o.ready;

  // new entry built from an add item
  always_comb begin
    add_start = tws_pkg::wrap_day(12'(in_i.payload.new_start_hour) *
                                  12'(tws_pkg::MinsPerHour) +
                                  12'(in_i.payload.new_start_minute));
    add_dur   = tws_pkg::wrap_day(12'(in_i.payload.new_duration));
    add_entry.day_mask   = in_i.payload.new_day_mask;
    add_entry.start_min  = add_start;
    add_entry.end_min    = tws_pkg::wrap_day(12'(add_start) + 12'(add_dur));
    add_entry.start_code = in_i.payload.new_start_code;
    add_entry.end_code   = in_i.payload.new_end_code;
    add_entry.last_sent  = 4'd0;
  end

  assign tick_ok = in_i.payload.time_valid &&
                   (in_i.payload.cur_hour < 5'(tws_pkg::HoursPerDay)) &&
                   (in_i.payload.cur_minute < 6'(tws_pkg::MinsPerHour));

  // a fired code in the walk that still counts toward the run
  assign new_res = rd_vld_q && ev.fire && (n_q < ResCntW'(tws_pkg::ResultLimit));
  // the held result cannot move on while the output register is full
  assign stall   = new_res && pend_v_q && !out_free;

  // next-state logic
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    ev_idx_d    = ev_idx_q;
    rd_vld_d    = rd_vld_q;
    now_d       = now_q;
    wday_d      = wday_q;
    pend_v_d    = pend_v_q;
    pend_idx_d  = pend_idx_q;
    pend_code_d = pend_code_q;
    n_d         = n_q;
    out_v_d     = out_v_q && !out_o.ready;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = ev_idx_q;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = rd_idx_q[IdxW-1:0];

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_i.payload.mode == tws_pkg::ModeAdd) begin
            out_v_d = 1'b1;
            if (count_q < CntW'(MaxEntries)) begin
              mem_we    = 1'b1;
              mem_waddr = count_q[IdxW-1:0];
              mem_wdata = add_entry;
              out_d     = '{out_kind: tws_pkg::KindAdded, entry_index: 4'(count_q),
                            event_code: 4'd0, last: 1'b1};
              count_d   = count_q + 1'b1;
            end else begin
              out_d     = '{out_kind: tws_pkg::KindFull, entry_index: 4'd0,
                            event_code: 4'd0, last: 1'b1};
            end
          end else if (tick_ok) begin
            now_d    = 11'(12'(in_i.payload.cur_hour) * 12'(tws_pkg::MinsPerHour) +
                           12'(in_i.payload.cur_minute));
            wday_d   = in_i.payload.weekday;
            rd_idx_d = '0;
            rd_vld_d = 1'b0;
            pend_v_d = 1'b0;
            n_d      = '0;
            state_d  = StWalk;
          end
        end
      end

      StWalk: begin
        if (!stall) begin
          // write back the entry just evaluated
          if (rd_vld_q) begin
            mem_we              = 1'b1;
            mem_waddr           = ev_idx_q;
            mem_wdata.last_sent = ev.last_sent;
            if (new_res) begin
              if (pend_v_q) begin
                out_v_d = 1'b1;
                out_d   = '{out_kind: tws_pkg::KindEvent, entry_index: 4'(pend_idx_q),
                            event_code: pend_code_q, last: 1'b0};
              end
              pend_v_d    = 1'b1;
              pend_idx_d  = ev_idx_q;
              pend_code_d = ev.code;
              n_d         = n_q + 1'b1;
            end
          end
          // fetch the next entry, or finish once the last one is back
          if (rd_idx_q < count_q) begin
            mem_re   = 1'b1;
            ev_idx_d = rd_idx_q[IdxW-1:0];
            rd_idx_d = rd_idx_q + 1'b1;
            rd_vld_d = 1'b1;
          end else begin
            rd_vld_d = 1'b0;
            if (!rd_vld_q) begin
              state_d = StFlush;
            end
          end
        end
      end

      StFlush: begin
        // the held result closes the run
        if (!pend_v_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_v_d  = 1'b1;
          out_d    = '{out_kind: tws_pkg::KindEvent, entry_index: 4'(pend_idx_q),
                       event_code: pend_code_q, last: 1'b1};
          pend_v_d = 1'b0;
          state_d  = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
      pend_v_q <= 1'b0;
      n_q      <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      rd_vld_q <= rd_vld_d;
      pend_v_q <= pend_v_d;
      n_q      <= n_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ev_idx_q    <= ev_idx_d;
    now_q       <= now_d;
    wday_q      <= wday_d;
    pend_idx_q  <= pend_idx_d;
    pend_code_q <= pend_code_d;
    out_q       <= out_d;
  end

endmodule

### design/tws_checker.sv
// tws_checker: port-level checks of the time-window event scheduler, with its bind
// depends on tws_pkg for mode and kind codes
module tws_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_mode_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i,
  input logic [3:0] out_code_i,
  input logic       out_last_i
);

  // a result that is offered stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  // an item is only taken while no result is waiting
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i)
    else $error("item accepted while a result was pending");

  // an add item answers with one closing acknowledgement next cycle
  a_add_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == tws_pkg::ModeAdd) |=>
      out_valid_i && out_last_i &&
      ((out_kind_i == tws_pkg::KindAdded) || (out_kind_i == tws_pkg::KindFull)) &&
      (out_code_i == 4'd0))
    else $error("add item without a proper acknowledgement");

  // fired results never carry the empty code
  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == tws_pkg::KindEvent) |-> (out_code_i != 4'd0))
    else $error("event result with empty code");

  // kind three is never produced
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_kind_i != 2'd3))
    else $error("unknown result kind");

endmodule

bind time_window_event_scheduler tws_checker u_tws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.payload.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.payload.out_kind),
  .out_code_i  (out_o.payload.event_code),
  .out_last_i  (out_o.payload.last)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for the time-window event scheduler
// depends on tws_pkg and the tws_in_if / tws_out_if channels; it predicts every result
// from its own copy of the window table and checks each one as it comes out
module tb_top;

  localparam int unsigned Slots       = tws_pkg::MaxEntriesDef;
  localparam int unsigned RandomItems = 150;
  localparam int unsigned AddTarget   = Slots + 2;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned TailCycles  = 40;

  // receiver stall styles
  localparam logic [1:0] SinkOpen    = 2'd0;
  localparam logic [1:0] SinkRandom  = 2'd1;
  localparam logic [1:0] SinkPattern = 2'd2;

  typedef struct {
    tws_pkg::in_item_t item;
    bit                settle;
  } load_t;

  typedef struct {
    logic [6:0]  days;
    int unsigned open_min;
    int unsigned close_min;
    logic [3:0]  open_code;
    logic [3:0]  close_code;
    logic [3:0]  sent;
  } window_t;

  logic clk_i;
  logic rst_ni;

  tws_in_if  req_ch ();
  tws_out_if rsp_ch ();

  time_window_event_scheduler #(
    .MaxEntries(Slots)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch),
    .out_o (rsp_ch)
  );

  // stimulus store and generator bookkeeping
  load_t       load_q[$];
  bit          settle_next;
  int unsigned load_count;
  int unsigned adds_queued;
  int unsigned wins;
  int unsigned win_open[Slots];
  int unsigned win_close[Slots];
  logic [6:0]  win_days[Slots];

  // predictor state
  window_t             windows[Slots];
  int unsigned         slots_used;
  tws_pkg::out_item_t  results_due[$];

  // run status
  int unsigned mismatches;
  int unsigned idle_cycles;
  logic        results_clear;
  logic        feed_empty;
  int unsigned items_taken, results_taken, added_n, full_n, fired_n;

  // driver scratch
  int unsigned       gap_left, burst_left;
  logic              next_valid;
  tws_pkg::in_item_t next_item;
  load_t             slot;

  // receiver pattern
  logic [1:0] sink_mode;
  logic [6:0] sink_phase;
  logic [7:0] sink_pattern;

  // fold a minute count into one day
  function automatic int unsigned day_fold(input int unsigned v);
    return v % tws_pkg::MinsPerDay;
  endfunction

  // all fields random; callers overwrite the ones that matter
  function automatic tws_pkg::in_item_t noise_item();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(tws_pkg::in_item_t)-1:0];
  endfunction

  task automatic queue_item(input tws_pkg::in_item_t it);
    load_t l;
    l.item = it;
    l.settle = settle_next;
    settle_next = 1'b0;
    load_q.push_back(l);
  endtask

  task automatic queue_add(input logic [6:0] mask, input logic [3:0] scode,
                           input logic [4:0] hr, input logic [5:0] mn,
                           input logic [10:0] dur, input logic [3:0] ecode);
    tws_pkg::in_item_t it;
    it = noise_item();
    it.mode = tws_pkg::ModeAdd;
    it.new_day_mask = mask;
    it.new_start_code = scode;
    it.new_start_hour = hr;
    it.new_start_minute = mn;
    it.new_duration = dur;
    it.new_end_code = ecode;
    if (wins < Slots) begin
      win_open[wins] = day_fold(int'(hr) * tws_pkg::MinsPerHour + int'(mn));
      win_close[wins] = day_fold(win_open[wins] + int'(dur));
      win_days[wins] = mask;
      wins++;
    end
    adds_queued++;
    load_count++;
    queue_item(it);
  endtask

  task automatic queue_tick(input logic ok, input logic [4:0] hr, input logic [5:0] mn,
                            input logic [2:0] wd);
    tws_pkg::in_item_t it;
    it = noise_item();
    it.mode = tws_pkg::ModeTick;
    it.time_valid = ok;
    it.cur_hour = hr;
    it.cur_minute = mn;
    it.weekday = wd;
    if (ok && hr < tws_pkg::HoursPerDay && mn < tws_pkg::MinsPerHour) load_count++;
    queue_item(it);
  endtask

  // tick at a minute of the day
  task automatic queue_tick_at(input int unsigned m, input logic [2:0] wd);
    queue_tick(1'b1, 5'(m / tws_pkg::MinsPerHour), 6'(m % tws_pkg::MinsPerHour), wd);
  endtask

  // expected results of one accepted item; updates the predicted table
  task automatic predict_item(input tws_pkg::in_item_t it);
    int unsigned        now, i, count;
    logic               allowed, is_open, handled, have_held;
    logic [3:0]         code;
    tws_pkg::out_item_t res, held;
    if (it.mode == tws_pkg::ModeAdd) begin
      res.event_code = 4'd0;
      res.last = 1'b1;
      if (slots_used < Slots) begin
        now = day_fold(int'(it.new_start_hour) * tws_pkg::MinsPerHour +
                       int'(it.new_start_minute));
        windows[slots_used].days = it.new_day_mask;
        windows[slots_used].open_min = now;
        windows[slots_used].close_min = day_fold(now + day_fold(int'(it.new_duration)));
        windows[slots_used].open_code = it.new_start_code;
        windows[slots_used].close_code = it.new_end_code;
        windows[slots_used].sent = 4'd0;
        res.out_kind = tws_pkg::KindAdded;
        res.entry_index = 4'(slots_used);
        slots_used++;
        added_n++;
      end else begin
        res.out_kind = tws_pkg::KindFull;
        res.entry_index = 4'd0;
        full_n++;
      end
      results_due.push_back(res);
    end else if (it.time_valid && it.cur_hour < tws_pkg::HoursPerDay &&
                 it.cur_minute < tws_pkg::MinsPerHour) begin
      now = int'(it.cur_hour) * tws_pkg::MinsPerHour + int'(it.cur_minute);
      count = 0;
      have_held = 1'b0;
      for (i = 0; i < slots_used; i++) begin
        allowed = 1'b0;
        if (it.weekday < 3'd7) allowed = windows[i].days[it.weekday];
        // a disallowed day still lets an entry that has sent a code finish its window
        if (allowed || windows[i].sent != 4'd0) begin
          if (windows[i].open_min <= windows[i].close_min)
            is_open = now >= windows[i].open_min && now <= windows[i].close_min;
          else
            is_open = now >= windows[i].open_min || now <= windows[i].close_min;
          code = 4'd0;
          handled = 1'b0;
          if (is_open) begin
            if (windows[i].sent == 4'd0) begin
              windows[i].sent = windows[i].open_code;
              code = windows[i].open_code;
              handled = 1'b1;
            end else if (windows[i].sent == windows[i].open_code &&
                         now == windows[i].close_min) begin
              windows[i].sent = windows[i].close_code;
              code = windows[i].close_code;
              handled = 1'b1;
            end
          end
          // re-arm once the end code has gone out
          if (!handled && windows[i].sent == windows[i].close_code) windows[i].sent = 4'd0;
          if (code != 4'd0 && count < tws_pkg::ResultLimit) begin
            if (have_held) results_due.push_back(held);
            held.out_kind = tws_pkg::KindEvent;
            held.entry_index = 4'(i);
            held.event_code = code;
            held.last = 1'b0;
            have_held = 1'b1;
            count++;
            fired_n++;
          end
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        results_due.push_back(held);
      end
    end
  endtask

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // stimulus: directed items, then random window walks, random and malformed ticks, with adds until the table overflows
  initial begin
    int unsigned directed_n, k, s, e, t, r, pick;
    logic [2:0]  wd;
    int unsigned walk[7];
    settle_next = 1'b0;
    load_count = 0;
    adds_queued = 0;
    wins = 0;

    queue_tick(1'b1, 5'd9, 6'd30, 3'd3);                  // empty table
    queue_add(7'h7f, 4'd1, 5'd23, 6'd50, 11'd20, 4'd2);   // crosses midnight
    queue_add(7'h01, 4'd3, 5'd0, 6'd0, 11'd0, 4'd3);      // zero length, equal codes
    queue_add(7'h40, 4'd15, 5'd31, 6'd63, 11'd2047, 4'd0); // start and length wrap, no end code
    queue_add(7'h00, 4'd0, 5'd12, 6'd0, 11'd1439, 4'd15); // no allowed day, no start code
    queue_add(7'h2a, 4'd7, 5'd23, 6'd59, 11'd1, 4'd8);    // ends exactly at midnight
    settle_next = 1'b1;
    queue_tick(1'b1, 5'd23, 6'd50, 3'd0);
    queue_tick(1'b1, 5'd23, 6'd59, 3'd0);
    queue_tick(1'b1, 5'd0, 6'd10, 3'd0);
    queue_tick(1'b1, 5'd0, 6'd0, 3'd0);
    queue_tick(1'b1, 5'd0, 6'd0, 3'd0);
    queue_tick(1'b1, 5'd0, 6'd0, 3'd0);
    queue_tick(1'b0, 5'd0, 6'd10, 3'd1);                  // clock not synchronized
    queue_tick(1'b1, 5'd24, 6'd0, 3'd1);                  // hour out of range
    queue_tick(1'b1, 5'd0, 6'd60, 3'd1);                  // minute out of range
    queue_tick(1'b1, 5'd31, 6'd63, 3'd7);
    queue_tick(1'b1, 5'd8, 6'd3, 3'd6);
    queue_tick(1'b1, 5'd18, 6'd10, 3'd6);                 // end minute with no end code
    queue_tick(1'b1, 5'd23, 6'd59, 3'd5);
    queue_tick(1'b1, 5'd0, 6'd0, 3'd7);                   // weekday seven, started entry ends
    queue_tick(1'b1, 5'd12, 6'd0, 3'd2);

    directed_n = load_count;
    settle_next = 1'b1;
    while (load_count < directed_n + RandomItems) begin
      if ($urandom_range(0, 19) == 0) settle_next = 1'b1;
      r = $urandom_range(0, 99);
      if (adds_queued < AddTarget &&
          (r < 8 || directed_n + RandomItems - load_count < 25)) begin
        queue_add(7'($urandom_range(0, 127)),
                  ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15)),
                  ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                              : 5'($urandom_range(0, 23)),
                  ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                              : 6'($urandom_range(0, 59)),
                  ($urandom_range(0, 9) == 0) ? 11'($urandom_range(1440, 2047)) :
                  ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 5))
                                              : 11'($urandom_range(0, 1439)),
                  4'($urandom_range(0, 15)));
        // sometimes make the end code equal to the start code
        if ($urandom_range(0, 6) == 0)
          load_q[load_q.size()-1].item.new_end_code =
            load_q[load_q.size()-1].item.new_start_code;
      end else if (r < 70) begin
        // walk through one window: edges, inside, the end minute twice
        k = $urandom_range(0, wins - 1);
        s = win_open[k];
        e = win_close[k];
        if (win_days[k] != 7'd0 && $urandom_range(0, 4) != 0) begin
          pick = $urandom_range(0, 6);
          while (!win_days[k][pick]) pick = (pick + 1) % 7;
          wd = 3'(pick);
        end else begin
          wd = 3'($urandom_range(0, 7));
        end
        t = (e >= s) ? e - s : e + tws_pkg::MinsPerDay - s;
        walk[0] = day_fold(s + tws_pkg::MinsPerDay - 1);
        walk[1] = s;
        walk[2] = day_fold(s + $urandom_range(0, t));
        walk[3] = day_fold(e + tws_pkg::MinsPerDay - 1);
        walk[4] = e;
        walk[5] = e;
        walk[6] = day_fold(e + 1);
        for (int j = 0; j < 7; j++)
          if ($urandom_range(0, 99) < 85) queue_tick_at(walk[j], wd);
      end else if (r < 88) begin
        queue_tick_at($urandom_range(0, tws_pkg::MinsPerDay - 1), 3'($urandom_range(0, 7)));
      end else begin
        // malformed ticks the block must ignore
        case ($urandom_range(0, 2))
          0: queue_tick(1'b0, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                        3'($urandom_range(0, 7)));
          1: queue_tick(1'b1, 5'($urandom_range(24, 31)), 6'($urandom_range(0, 63)),
                        3'($urandom_range(0, 7)));
          default: queue_tick(1'b1, 5'($urandom_range(0, 31)), 6'($urandom_range(60, 63)),
                              3'($urandom_range(0, 7)));
        endcase
      end
    end
  end

  // driver: bursts with random gaps; a settle item waits until every result is in
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      feed_empty <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else if (!req_ch.valid || req_ch.ready) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (load_q.size() != 0 &&
                   (!load_q[0].settle || (results_clear && !req_ch.valid))) begin
        slot = load_q.pop_front();
        next_item = slot.item;
        next_valid = 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      req_ch.valid <= next_valid;
      if (next_valid) req_ch.payload <= next_item;
      feed_empty <= !next_valid && load_q.size() == 0;
    end
  end

  // receiver: ready style changes each time the 7-bit phase counter wraps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      sink_mode <= SinkOpen;
      sink_phase <= 7'd1;
      sink_pattern <= 8'hff;
    end else begin
      sink_phase <= sink_phase + 7'd1;
      if (sink_phase == 7'd0) begin
        sink_mode <= 2'($urandom_range(0, 2));
        sink_pattern <= 8'($urandom_range(0, 255)) | 8'h01;
      end
      case (sink_mode)
        SinkOpen:   rsp_ch.ready <= 1'b1;
        SinkRandom: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
        default:    rsp_ch.ready <= sink_pattern[sink_phase[2:0]];
      endcase
    end
  end

  // monitor: check results against the oldest expectation, then predict new items
  always @(posedge clk_i or negedge rst_ni) begin
    tws_pkg::out_item_t want, got;
    if (!rst_ni) begin
      slots_used = 0;
      mismatches = 0;
      items_taken = 0;
      results_taken = 0;
      added_n = 0;
      full_n = 0;
      fired_n = 0;
      idle_cycles <= 0;
      results_clear <= 1'b1;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.payload;
        results_taken++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result kind=%0d idx=%0d code=%0d last=%0d", $realtime,
                     got.out_kind, got.entry_index, got.event_code, got.last);
        end else begin
          want = results_due.pop_front();
          if (got.out_kind !== want.out_kind || got.entry_index !== want.entry_index ||
              got.event_code !== want.event_code || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch: expected kind=%0d idx=%0d code=%0d last=%0d,",
                        " got kind=%0d idx=%0d code=%0d last=%0d"},
                       $realtime, want.out_kind, want.entry_index, want.event_code, want.last,
                       got.out_kind, got.entry_index, got.event_code, got.last);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        items_taken++;
        predict_item(req_ch.payload);
      end
      idle_cycles <= ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) ?
                     0 : idle_cycles + 1;
      results_clear <= (results_due.size() == 0);
    end
  end

  // end of run: drain, let the last walk finish, report
  initial begin
    int unsigned leftover;
    @(posedge rst_ni);
    while (!(feed_empty && results_clear) && idle_cycles < IdleLimit) @(posedge clk_i);
    if (idle_cycles < IdleLimit) repeat (TailCycles) @(posedge clk_i);
    if (idle_cycles >= IdleLimit)
      $display("watchdog: nothing moved for %0d cycles", IdleLimit);
    leftover = results_due.size();
    if (leftover != 0) $display("%0d expected results never arrived", leftover);
    $display("covered %0d items: %0d entries added, %0d adds refused on a full table",
             items_taken, added_n, full_n);
    $display("checked %0d results, %0d of them fired events", results_taken, fired_n);
    if (idle_cycles < IdleLimit && mismatches == 0 && leftover == 0) begin
      $display("time_window_event_scheduler test passed");
    end else begin
      $display("time_window_event_scheduler test failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/tws_pkg.sv
design/tws_in_if.sv
design/tws_out_if.sv
design/tws_entry_ram.sv
design/tws_window_eval.sv
design/time_window_event_scheduler.sv
design/tws_checker.sv
tb/sv/tb_top.sv
